[src/ltc_enc_pkg.sv]
// Shared types, constants and helper functions for the LTC frame encoder.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package ltc_enc_pkg;

  localparam int unsigned FrameBytes = 10;
  localparam int unsigned DataBytes  = 8;
  localparam int unsigned ByteIdxW   = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 2;

  localparam logic [ByteIdxW-1:0] LastByteIdx  = ByteIdxW'(FrameBytes - 1);
  localparam logic [ByteIdxW-1:0] SyncByteIdx0 = ByteIdxW'(DataBytes);

  localparam logic [7:0] SyncByte0 = 8'h3F;
  localparam logic [7:0] SyncByte1 = 8'hFD;

  localparam logic [CfgIdxW-1:0] CfgFrameRate = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgExtClock  = 2'd1;

  localparam logic [1:0] Rate24     = 2'd0;
  localparam logic [1:0] Rate25     = 2'd1;
  localparam logic [1:0] Rate30Drop = 2'd2;
  localparam logic [1:0] Rate30     = 2'd3;

  typedef struct packed {
    logic load_frame;
    logic emit_byte;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_byte;
  } ctrl_status_t;

  typedef struct packed {
    logic [15:0] levels;
    logic        end_level;
  } biphase_t;

  // Tens digit of a value of at most 59.
  function automatic logic [2:0] tens_digit(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd50) begin
      t = 3'd5;
    end else if (v >= 6'd40) begin
      t = 3'd4;
    end else if (v >= 6'd30) begin
      t = 3'd3;
    end else if (v >= 6'd20) begin
      t = 3'd2;
    end else if (v >= 6'd10) begin
      t = 3'd1;
    end else begin
      t = 3'd0;
    end
    return t;
  endfunction

  function automatic logic [3:0] units_digit(input logic [5:0] v, input logic [2:0] t);
    logic [5:0] t10;
    logic [5:0] u;
    t10 = {t, 3'b000} + {2'b00, t, 1'b0};
    u   = v - t10;
    return u[3:0];
  endfunction

  // A digit placed so that its least significant bit is sent first.
  function automatic logic [7:0] digit_byte(input logic [3:0] d);
    return {d[0], d[1], d[2], d[3], 4'b0000};
  endfunction

  // Biphase-mark coding of one byte, most significant bit first.
  function automatic biphase_t biphase(input logic [7:0] b, input logic start_level);
    biphase_t r;
    logic     lvl;
    logic     first;
    logic     second;
    lvl = start_level;
    r.levels = '0;
    for (int i = 7; i >= 0; i--) begin
      first  = ~lvl;
      second = first ^ b[i];
      r.levels[2*i+1] = first;
      r.levels[2*i]   = second;
      lvl = second;
    end
    r.end_level = lvl;
    return r;
  endfunction

endpackage

`default_nettype wire

[src/ltc_enc_ctrl.sv]
// Controller state machine of the LTC frame encoder.
// Depends on ltc_enc_pkg; drives load and emit commands into ltc_enc_dp.
`default_nettype none

module ltc_enc_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire ltc_enc_pkg::ctrl_status_t status_i,
  output ltc_enc_pkg::ctrl_cmd_t         cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StSend = 1'b1;

  logic state_q;
  logic state_d;
  logic emit;
  logic accept;

  assign emit       = (state_q == StSend) && status_i.out_free;
  assign in_stall_o = !((state_q == StIdle) || (emit && status_i.last_byte));
  assign accept     = in_valid_i && !in_stall_o;

  assign cmd_o.load_frame = accept;
  assign cmd_o.emit_byte  = emit;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StSend;
        end
      end
      StSend: begin
        if (emit && status_i.last_byte) begin
          state_d = accept ? StSend : StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[src/ltc_enc_dp.sv]
// Datapath of the LTC frame encoder: configuration, frame register,
// biphase-mark coder and output register. Depends on ltc_enc_pkg.
`default_nettype none

module ltc_enc_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  input  wire logic [ltc_enc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [ltc_enc_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic [4:0]                           frame_number_i,
  input  wire logic [5:0]                           second_number_i,
  input  wire logic [5:0]                           minute_number_i,
  input  wire logic [4:0]                           hour_number_i,
  input  wire ltc_enc_pkg::ctrl_cmd_t               cmd_i,
  output ltc_enc_pkg::ctrl_status_t                 status_o,
  input  wire logic                                 out_stall_i,
  output logic                                      out_valid_o,
  output logic [ltc_enc_pkg::ByteIdxW-1:0]          byte_index_o,
  output logic [7:0]                                frame_byte_o,
  output logic [15:0]                               half_bit_levels_o,
  output logic                                      last_of_frame_o
);

  logic [1:0] rate_q;
  logic       ext_clk_q;

  logic [5:0] sat_val [4];
  logic [2:0] tens    [4];
  logic [3:0] units   [4];
  logic [7:0] new_byte [ltc_enc_pkg::DataBytes];
  logic [7:0] frame_q  [ltc_enc_pkg::DataBytes];
  logic [63:0] data_bits;

  logic [ltc_enc_pkg::ByteIdxW-1:0] count_q;
  logic                             level_q;
  logic                             out_valid_q;
  logic [ltc_enc_pkg::ByteIdxW-1:0] out_index_q;
  logic [7:0]                       out_byte_q;
  logic [15:0]                      out_levels_q;
  logic                             out_last_q;

  logic [7:0]             cur_byte;
  ltc_enc_pkg::biphase_t  coded;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= ltc_enc_pkg::Rate24;
      ext_clk_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ltc_enc_pkg::CfgFrameRate) begin
        rate_q <= cfg_data_i[1:0];
      end else if (cfg_index_i == ltc_enc_pkg::CfgExtClock) begin
        ext_clk_q <= cfg_data_i[0];
      end
    end
  end

  always_comb begin
    sat_val[0] = (frame_number_i > 5'd29) ? 6'd29 : {1'b0, frame_number_i};
    sat_val[1] = (second_number_i > 6'd59) ? 6'd59 : second_number_i;
    sat_val[2] = (minute_number_i > 6'd59) ? 6'd59 : minute_number_i;
    sat_val[3] = (hour_number_i > 5'd23) ? 6'd23 : {1'b0, hour_number_i};
    for (int k = 0; k < 4; k++) begin
      tens[k]            = ltc_enc_pkg::tens_digit(sat_val[k]);
      units[k]           = ltc_enc_pkg::units_digit(sat_val[k], tens[k]);
      new_byte[2*k]      = ltc_enc_pkg::digit_byte(units[k]);
      new_byte[2*k+1]    = ltc_enc_pkg::digit_byte({1'b0, tens[k]});
    end
    if (rate_q == ltc_enc_pkg::Rate30Drop) begin
      new_byte[1][5] = 1'b1;
    end
    if (ext_clk_q) begin
      new_byte[7][5] = 1'b1;
    end
    for (int k = 0; k < 8; k++) begin
      data_bits[8*k +: 8] = new_byte[k];
    end
    if (!(^data_bits)) begin
      if (rate_q == ltc_enc_pkg::Rate25) begin
        new_byte[7][4] = 1'b1;
      end else begin
        new_byte[3][4] = 1'b1;
      end
    end
  end

  always_comb begin
    priority if (count_q < ltc_enc_pkg::SyncByteIdx0) begin
      cur_byte = frame_q[count_q[2:0]];
    end else if (count_q == ltc_enc_pkg::SyncByteIdx0) begin
      cur_byte = ltc_enc_pkg::SyncByte0;
    end else begin
      cur_byte = ltc_enc_pkg::SyncByte1;
    end
    coded = ltc_enc_pkg::biphase(cur_byte, level_q);
  end

  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign status_o.last_byte = (count_q == ltc_enc_pkg::LastByteIdx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_frame) begin
      frame_q <= new_byte;
    end
    if (cmd_i.emit_byte) begin
      out_index_q  <= count_q;
      out_byte_q   <= cur_byte;
      out_levels_q <= coded.levels;
      out_last_q   <= (count_q == ltc_enc_pkg::LastByteIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      level_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit_byte) begin
        out_valid_q <= 1'b1;
        count_q     <= count_q + {{(ltc_enc_pkg::ByteIdxW-1){1'b0}}, 1'b1};
        level_q     <= coded.end_level;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load_frame) begin
        count_q <= '0;
        level_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign byte_index_o      = out_index_q;
  assign frame_byte_o      = out_byte_q;
  assign half_bit_levels_o = out_levels_q;
  assign last_of_frame_o   = out_last_q;

endmodule

`default_nettype wire

[src/ltc_timecode_frame_encoder_core.sv]
// Top level of the LTC timecode frame encoder.
// Depends on ltc_enc_pkg, ltc_enc_ctrl and ltc_enc_dp.
//
// Usage: a timecode request (frames, seconds, minutes, hours) is taken on
// the input channel when in_valid_i is high and in_stall_o is low. The
// encoder builds the 64 data bits of the frame in that cycle and then sends
// ten results on the output channel, one per frame byte, data bytes first and
// the two sync bytes last. Each result carries the byte and its sixteen
// biphase-mark half-bit levels; the line starts low at every frame.
// After a request is taken, the controller enters its send state and the
// results follow one per cycle while out_stall_i is low. A new request
// is taken in the cycle the tenth result is loaded into the output
// register, which takes one byte per cycle.
// When the receiver stalls, the output register holds its result and the
// byte sequencer waits. Configuration writes are always ready and should be
// made while the encoder is idle. Reset clears the configuration to 24 fps
// with the external clock flag low and leaves the encoder idle.
`default_nettype none

module ltc_timecode_frame_encoder_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [ltc_enc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ltc_enc_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [4:0]                       frame_number_i,
  input  wire logic [5:0]                       second_number_i,
  input  wire logic [5:0]                       minute_number_i,
  input  wire logic [4:0]                       hour_number_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [ltc_enc_pkg::ByteIdxW-1:0]      byte_index_o,
  output logic [7:0]                            frame_byte_o,
  output logic [15:0]                           half_bit_levels_o,
  output logic                                  last_of_frame_o
);

  ltc_enc_pkg::ctrl_cmd_t    cmd;
  ltc_enc_pkg::ctrl_status_t status;

  assign cfg_ready_o = 1'b1;

  ltc_enc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ltc_enc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .frame_number_i    (frame_number_i),
    .second_number_i   (second_number_i),
    .minute_number_i   (minute_number_i),
    .hour_number_i     (hour_number_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .byte_index_o      (byte_index_o),
    .frame_byte_o      (frame_byte_o),
    .half_bit_levels_o (half_bit_levels_o),
    .last_of_frame_o   (last_of_frame_o)
  );

endmodule

`default_nettype wire

[src/ltc_enc_checker.sv]
// Port-level checker for the LTC frame encoder, bound to the top level.
// Depends on ltc_enc_pkg and ltc_timecode_frame_encoder_core.
`default_nettype none

module ltc_enc_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             out_valid_i,
  input wire logic                             out_stall_i,
  input wire logic [ltc_enc_pkg::ByteIdxW-1:0] byte_index_i,
  input wire logic [7:0]                       frame_byte_i,
  input wire logic [15:0]                      half_bit_levels_i,
  input wire logic                             last_of_frame_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(byte_index_i)
      && $stable(frame_byte_i) && $stable(half_bit_levels_i))
    else $error("Stalled result changed.");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_of_frame_i == (byte_index_i == ltc_enc_pkg::LastByteIdx)))
    else $error("Last-of-frame flag does not match the byte index.");

  a_sync_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (byte_index_i == ltc_enc_pkg::SyncByteIdx0 ||
      byte_index_i == ltc_enc_pkg::LastByteIdx) |->
      frame_byte_i == ((byte_index_i == ltc_enc_pkg::SyncByteIdx0) ?
        ltc_enc_pkg::SyncByte0 : ltc_enc_pkg::SyncByte1))
    else $error("Sync byte has the wrong value.");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && byte_index_i == '0 |->
      half_bit_levels_i[15] && (half_bit_levels_i[14] == !frame_byte_i[7]))
    else $error("First bit of the frame is not coded from a low line.");

endmodule

bind ltc_timecode_frame_encoder_core ltc_enc_checker u_ltc_enc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .byte_index_i      (byte_index_o),
  .frame_byte_i      (frame_byte_o),
  .half_bit_levels_i (half_bit_levels_o),
  .last_of_frame_i   (last_of_frame_o)
);

`default_nettype wire
